// File: hw/rtl/tbc_pkg.sv
// shared types, constants and round functions for the tweakable block cipher
`default_nettype none
package tbc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } reg_index_t;

  localparam int NumRounds = 16;

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic byte_t get_byte(block_t b, int i);
    get_byte = b[127 - 8 * i -: 8];
  endfunction

  function automatic byte_t round_const(logic [4:0] r);
    case (r)
      5'd0:  round_const = 8'h2f;
      5'd1:  round_const = 8'h5e;
      5'd2:  round_const = 8'hbc;
      5'd3:  round_const = 8'h63;
      5'd4:  round_const = 8'hc6;
      5'd5:  round_const = 8'h97;
      5'd6:  round_const = 8'h35;
      5'd7:  round_const = 8'h6a;
      5'd8:  round_const = 8'hd4;
      5'd9:  round_const = 8'hb3;
      5'd10: round_const = 8'h7d;
      5'd11: round_const = 8'hfa;
      5'd12: round_const = 8'hef;
      5'd13: round_const = 8'hc5;
      5'd14: round_const = 8'h91;
      5'd15: round_const = 8'h39;
      5'd16: round_const = 8'h72;
      default: round_const = 8'h00;
    endcase
  endfunction

  function automatic byte_t sbox(byte_t x);
    byte_t tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = tab[x];
  endfunction

  function automatic byte_t gf_dbl(byte_t x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // h permutation of a tweakey word
  function automatic block_t permute(block_t t);
    int perm [16];
    block_t o;
    perm = '{1, 6, 11, 12, 5, 10, 15, 0, 9, 14, 3, 4, 13, 2, 7, 8};
    o = '0;
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = get_byte(t, perm[i]);
    permute = o;
  endfunction

  function automatic block_t lfsr2(block_t t);
    block_t o;
    byte_t b;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      b = get_byte(t, i);
      o[127 - 8 * i -: 8] = {b[6:0], b[7] ^ b[5]};
    end
    lfsr2 = o;
  endfunction

  function automatic block_t lfsr3(block_t t);
    block_t o;
    byte_t b;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      b = get_byte(t, i);
      o[127 - 8 * i -: 8] = {b[0] ^ b[6], b[7:1]};
    end
    lfsr3 = o;
  endfunction

  // subtweakey addition for round r
  function automatic block_t add_tk(block_t s, block_t tk, logic [4:0] r);
    block_t rcw;
    rcw = {8'h01, 8'h02, 8'h04, 8'h08, {4{round_const(r)}}, 64'h0};
    add_tk = s ^ tk ^ rcw;
  endfunction

  function automatic block_t aes_round(block_t s);
    block_t o;
    byte_t t [16];
    byte_t a0, a1, a2, a3, all;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4 * c + r] = sbox(get_byte(s, 4 * ((c + r) % 4) + r));
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 32 * c -: 8]      = a0 ^ all ^ gf_dbl(a0 ^ a1);
      o[127 - 32 * c - 8 -: 8]  = a1 ^ all ^ gf_dbl(a1 ^ a2);
      o[127 - 32 * c - 16 -: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
      o[127 - 32 * c - 24 -: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
    end
    aes_round = o;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tweakable_block_cipher_encrypt_unit.sv
// Deoxys-BC-384 encryption pipeline, one AES round per round stage
//
//  channel   direction  handshake         payload
//  cfg       in         cfg_valid/ready   cfg_index, cfg_data
//  input     in         in_valid/stall    tweak_hi/lo, plain_hi/lo
//  output    out        out_valid/stall   cipher_hi/lo
//
// 17 register stages: 16 round stages and a last one that adds the final
// subtweakey and drives the outputs; the pipeline takes one block per cycle
// while the output does not stall.
// The key schedule for TK2/TK3 and TK1 travels with each block in its stage.
// Reset (rst, synchronous) clears valid bits and key registers.
// An output stall holds each full stage with no empty stage after it; other stages keep loading,
// so bubbles close up, and the input stalls only when all stages are full.
`default_nettype none
module tweakable_block_cipher_encrypt_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] tweak_hi,
  input  wire logic [63:0] tweak_lo,
  input  wire logic [63:0] plain_hi,
  input  wire logic [63:0] plain_lo,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      cipher_hi,
  output logic [63:0]      cipher_lo
);

  localparam int Stages = tbc_pkg::NumRounds + 1;

  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic [Stages-1:0] vld;
  tbc_pkg::block_t st [Stages];
  tbc_pkg::block_t tk1 [Stages];
  tbc_pkg::block_t tk2 [Stages];
  tbc_pkg::block_t tk3 [Stages];
  logic [Stages-1:0] adv;

  assign cfg_ready = 1'b1;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
    end else if (cfg_valid) begin
      case (tbc_pkg::reg_index_t'(cfg_index))
        tbc_pkg::REG_KEY_WORD0: key_word0 <= cfg_data;
        tbc_pkg::REG_KEY_WORD1: key_word1 <= cfg_data;
        tbc_pkg::REG_KEY_WORD2: key_word2 <= cfg_data;
        tbc_pkg::REG_KEY_WORD3: key_word3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage advance: a stage loads when it is empty or the one after moves
  always_comb begin
    adv[Stages-1] = !vld[Stages-1] || !out_stall;
    for (int k = Stages - 2; k >= 0; k--) adv[k] = !vld[k] || adv[k+1];
  end
  assign in_stall = !adv[0];

  // stage 0 takes the request and does round 0
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv[0]) vld[0] <= in_valid;
    if (adv[0]) begin
      st[0]  <= tbc_pkg::aes_round(tbc_pkg::add_tk({plain_hi, plain_lo},
                  {tweak_hi, tweak_lo} ^ {key_word2, key_word3} ^ {key_word0, key_word1},
                  5'd0));
      tk1[0] <= tbc_pkg::permute({tweak_hi, tweak_lo});
      tk2[0] <= tbc_pkg::permute(tbc_pkg::lfsr2({key_word2, key_word3}));
      tk3[0] <= tbc_pkg::permute(tbc_pkg::lfsr3({key_word0, key_word1}));
    end
  end

  // round stages 1..15, last stage adds the final subtweakey
  for (genvar g = 1; g < Stages; g++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) vld[g] <= 1'b0;
      else if (adv[g]) vld[g] <= vld[g-1];
      if (adv[g]) begin
        if (g == Stages - 1) begin
          st[g] <= tbc_pkg::add_tk(st[g-1], tk1[g-1] ^ tk2[g-1] ^ tk3[g-1], 5'(g));
        end else begin
          st[g] <= tbc_pkg::aes_round(tbc_pkg::add_tk(st[g-1],
                     tk1[g-1] ^ tk2[g-1] ^ tk3[g-1], 5'(g)));
        end
        tk1[g] <= tbc_pkg::permute(tk1[g-1]);
        tk2[g] <= tbc_pkg::permute(tbc_pkg::lfsr2(tk2[g-1]));
        tk3[g] <= tbc_pkg::permute(tbc_pkg::lfsr3(tk3[g-1]));
      end
    end
  end

  assign out_valid = vld[Stages-1];
  assign cipher_hi = st[Stages-1][127:64];
  assign cipher_lo = st[Stages-1][63:0];

endmodule
`default_nettype wire

// File: hw/rtl/tbc_checker.sv
// port-level checker for the cipher pipeline, bound to the top level
`default_nettype none
module tbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] cipher_hi,
  input wire logic [63:0] cipher_lo
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cipher_hi) && $stable(cipher_lo))
    else $error("stalled result changed");

  // input backs up only when the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled without output stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // an empty output stage never stalls input
  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("stall while output empty");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

endmodule

bind tweakable_block_cipher_encrypt_unit tbc_checker u_tbc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .cipher_hi(cipher_hi), .cipher_lo(cipher_lo)
);
`default_nettype wire

// File: bench/tweakable_block_cipher_encrypt_checker.sv
// checker: watches the request and result channels, computes expected ciphertext and compares
module tweakable_block_cipher_encrypt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] tweak_hi,
  input  logic [63:0] tweak_lo,
  input  logic [63:0] plain_hi,
  input  logic [63:0] plain_lo,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] cipher_hi,
  input  logic [63:0] cipher_lo,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_regs [4];
  tbc_pkg::block_t cipher_queue [$];
  int result_count;

  function automatic logic [7:0] sub_byte(logic [7:0] x);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // full 16-round encryption of one block, bytes column-major, byte 0 first
  function automatic tbc_pkg::block_t encrypt_block(logic [63:0] th, logic [63:0] tl,
                                                    logic [63:0] ph, logic [63:0] pl);
    logic [7:0] st [16];
    logic [7:0] t1 [16];
    logic [7:0] t2 [16];
    logic [7:0] t3 [16];
    logic [7:0] tmp [16];
    logic [7:0] p1 [16];
    logic [7:0] p2 [16];
    logic [7:0] p3 [16];
    logic [7:0] rcs [17];
    int hperm [16];
    logic [7:0] a0, a1, a2, a3, sum, rc, b;
    tbc_pkg::block_t res;
    rcs = '{8'h2f, 8'h5e, 8'hbc, 8'h63, 8'hc6, 8'h97, 8'h35, 8'h6a, 8'hd4,
            8'hb3, 8'h7d, 8'hfa, 8'hef, 8'hc5, 8'h91, 8'h39, 8'h72};
    hperm = '{1, 6, 11, 12, 5, 10, 15, 0, 9, 14, 3, 4, 13, 2, 7, 8};
    for (int i = 0; i < 8; i++) begin
      t1[i] = th[63 - 8 * i -: 8];  t1[i + 8] = tl[63 - 8 * i -: 8];
      st[i] = ph[63 - 8 * i -: 8];  st[i + 8] = pl[63 - 8 * i -: 8];
      t2[i] = key_regs[tbc_pkg::REG_KEY_WORD2][63 - 8 * i -: 8];
      t2[i + 8] = key_regs[tbc_pkg::REG_KEY_WORD3][63 - 8 * i -: 8];
      t3[i] = key_regs[tbc_pkg::REG_KEY_WORD0][63 - 8 * i -: 8];
      t3[i + 8] = key_regs[tbc_pkg::REG_KEY_WORD1][63 - 8 * i -: 8];
    end
    for (int r = 0; r <= 16; r++) begin
      // subtweakey addition
      for (int i = 0; i < 16; i++) begin
        rc = (i < 4) ? (8'h01 << i) : (i < 8) ? rcs[r] : 8'h00;
        st[i] = st[i] ^ t1[i] ^ t2[i] ^ t3[i] ^ rc;
      end
      if (r < 16) begin
        // sub bytes, shift rows, mix columns
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++)
            tmp[4 * c + w] = sub_byte(st[4 * ((c + w) % 4) + w]);
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4 * c]; a1 = tmp[4 * c + 1]; a2 = tmp[4 * c + 2]; a3 = tmp[4 * c + 3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          st[4 * c] = a0 ^ sum ^ xtime(a0 ^ a1);
          st[4 * c + 1] = a1 ^ sum ^ xtime(a1 ^ a2);
          st[4 * c + 2] = a2 ^ sum ^ xtime(a2 ^ a3);
          st[4 * c + 3] = a3 ^ sum ^ xtime(a3 ^ a0);
        end
        // tweakey schedule: byte lfsrs then h
        for (int i = 0; i < 16; i++) begin
          b = t2[i];  t2[i] = {b[6:0], b[7] ^ b[5]};
          b = t3[i];  t3[i] = {b[0] ^ b[6], b[7:1]};
        end
        for (int i = 0; i < 16; i++) begin
          p1[i] = t1[hperm[i]]; p2[i] = t2[hperm[i]]; p3[i] = t3[hperm[i]];
        end
        t1 = p1; t2 = p2; t3 = p3;
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
    return res;
  endfunction

  assign pending_count = cipher_queue.size();

  // track key writes, predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    tbc_pkg::block_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) key_regs[i] <= '0;
      cipher_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        cipher_queue.push_back(encrypt_block(tweak_hi, tweak_lo, plain_hi, plain_lo));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (cipher_queue.size() == 0) begin
          $display("%0t: unexpected result %h %h", $time, cipher_hi, cipher_lo);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_queue.pop_front();
          if (want[127:64] !== cipher_hi) begin
            $display("%0t: cipher_hi expected %h actual %h", $time, want[127:64], cipher_hi);
            fail_count <= fail_count + 1;
          end else if (want[63:0] !== cipher_lo) begin
            $display("%0t: cipher_lo expected %h actual %h", $time, want[63:0], cipher_lo);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) key_regs[cfg_index] <= cfg_data;
    end
  end
endmodule

// File: bench/tweakable_block_cipher_encrypt_unit_tb.sv
// testbench top: clock, reset, key writes, block stimulus and verdict
module tweakable_block_cipher_encrypt_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [63:0] tweak_hi = '0, tweak_lo = '0, plain_hi = '0, plain_lo = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] cipher_hi, cipher_lo;
  int fail_count, pending_count;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int block_count;

  always #5 clk = ~clk;

  tweakable_block_cipher_encrypt_unit uut (.*);

  tweakable_block_cipher_encrypt_checker checker_i (.*);

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random value with a bias toward all-zero and all-one fields
  function automatic logic [63:0] pick_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_key(tbc_pkg::reg_index_t idx, logic [63:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop offering, wait for every expected ciphertext, then let the pipeline drain
  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one request; valid stays up until an idle cycle or drain drops it
  task automatic send_block(logic [63:0] th, logic [63:0] tl, logic [63:0] ph,
                            logic [63:0] pl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    tweak_hi <= th; tweak_lo <= tl; plain_hi <= ph; plain_lo <= pl;
    do @(posedge clk); while (in_stall);
    block_count++;
  endtask

  task automatic new_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                         logic [63:0] k3);
    drain();
    write_key(tbc_pkg::REG_KEY_WORD0, k0);
    write_key(tbc_pkg::REG_KEY_WORD1, k1);
    write_key(tbc_pkg::REG_KEY_WORD2, k2);
    write_key(tbc_pkg::REG_KEY_WORD3, k3);
    cfg_valid <= 0;
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 0;
    block_count = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero key first, then extremes of every field
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    new_key('1, '1, '1, '1);
    send_block('0, '0, '0, '0);
    send_block('1, '1, '1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1, 64'h0123_4567_89ab_cdef,
               64'hfedc_ba98_7654_3210);
    new_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
            64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
    for (int i = 0; i < 8; i++) send_block(64'h1 << (8 * i), '1 >> i, 64'h80 << (7 * i), '0);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
               64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);

    // long receiver hold-off while the sender keeps offering
    hold_off <= 1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 30; i++) send_block(rand64(), rand64(), rand64(), rand64());
    join

    // random phases with changing idle ratios and keys
    for (int ph = 0; ph < 3; ph++) begin
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 24 : 0;
      new_key(pick_field(), pick_field(), pick_field(), pick_field());
      for (int i = 0; i < 280; i++) begin
        // short bursts with no idling at the end of every 70 requests
        send_idle_pct = (i % 70 >= 60) ? 0 : (ph == 0) ? 24 : (ph == 1) ? 82 : 0;
        send_block(pick_field(), pick_field(), pick_field(), pick_field());
      end
      send_idle_pct = 0;
      // sender pauses until every result is in
      drain();
    end

    drain();
    $display("encrypted %0d blocks across several keys, idle mixes and a long stall",
             block_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
